// File: hw/rtl/bpa_pkg.sv
// Package for the bitmap page allocator: sizes, opcodes and the
// controller/datapath command and status structs. No dependencies.
package bpa_pkg;
    localparam int unsigned NUM_PAGES = 4096;
    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned MAP_WORDS = NUM_PAGES / WORD_BITS;
    localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);
    localparam int unsigned BIT_AW    = $clog2(WORD_BITS);
    localparam int unsigned CNT_W     = 13;
    localparam int unsigned PAGE_W    = 12;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [CNT_W-1:0] LIMIT_RST = 13'd4096;
    localparam logic [CNT_W-1:0] PAGES_MAX = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic init_step;
        logic load;
        logic scan_start;
        logic scan_retry;
        logic scan_step;
        logic fetch_scan;
        logic fetch_wr;
        logic mark_step;
        logic clear_step;
        logic commit_alloc;
        logic commit_free;
        logic commit_fail;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic zero_req;
        logic scan_end;
        logic found;
        logic scan_wrap;
        logic wr_wrap;
        logic wr_done;
        logic init_done;
    } t_stat;
endpackage

// File: hw/rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: stream ports, controller and
// datapath. Uses bpa_pkg, bpa_ctrl, bpa_datapath.
// One request at a time. After reset a fill pass marks every page used;
// the input is not ready until it ends. An allocate scans the used map one
// page per cycle from the cursor to the limit and then from page 0 to the
// old cursor, pausing to fetch each new 64-page word, then marks the run
// one page per cycle the same way. A free clears the pages of its range
// that lie below the limit the same way. The next request can be taken in
// the cycle after the response is accepted.
module bitmap_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // first_page[11:0], page_count[24:12], zero
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // granted_page[11:0], free_total[24:12], zero
    output logic        m_axis_tuser   // granted
);
    import bpa_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  free;

    bpa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd));

    bpa_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_op(s_axis_tuser), .i_first(s_axis_tdata[11:0]),
        .i_count(s_axis_tdata[24:12]), .i_cmd(cmd), .o_stat(stat),
        .o_page(page), .o_ok(m_axis_tuser), .o_free(free));

    assign m_axis_tdata = {7'd0, free, page};
endmodule

// File: hw/rtl/bpa_datapath.sv
// Datapath of the bitmap page allocator: used map memory of 64-bit words,
// bit-serial run scanner and mark/clear walker on a registered word buffer,
// cursor and free count. Uses bpa_pkg.
module bpa_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_op,
    input  logic [bpa_pkg::PAGE_W-1:0] i_first,
    input  logic [bpa_pkg::CNT_W-1:0]  i_count,
    input  bpa_pkg::t_cmd              i_cmd,
    output bpa_pkg::t_stat             o_stat,
    output logic [bpa_pkg::PAGE_W-1:0] o_page,
    output logic                       o_ok,
    output logic [bpa_pkg::CNT_W-1:0]  o_free
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] wr_word;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
    logic                 mem_we;
    logic [WORD_AW-1:0]   r_fill;
    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_cursor, n_cursor;
    logic [CNT_W-1:0]     r_fcnt;
    logic                 r_op;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_pos, r_to, r_run, r_start, r_old, r_wr;
    logic [CNT_W-1:0]     r_left;
    logic                 r_found;
    logic [PAGE_W-1:0]    r_page;
    logic                 r_ok;
    logic [CNT_W-1:0]     lim, bound;
    logic                 bit_u;
    logic                 run_hit;
    logic                 wr_act;
    logic [CNT_W:0]       sum;

    assign lim     = (r_limit > PAGES_MAX) ? PAGES_MAX : r_limit;
    assign bound   = (r_old < lim) ? r_old : lim;
    assign bit_u   = r_word[r_pos[BIT_AW-1:0]];
    assign run_hit = !bit_u && (r_run + 1'b1 == r_n);
    // pages at or above the limit are left alone
    assign wr_act  = (i_cmd.mark_step || i_cmd.clear_step) && (r_wr < lim);
    assign sum     = {1'b0, r_fcnt} + {1'b0, r_n};

    always_comb begin
        wr_word = r_word;
        wr_word[r_wr[BIT_AW-1:0]] = i_cmd.mark_step;
    end

    assign mem_we    = i_cmd.init_step || wr_act;
    assign mem_waddr = i_cmd.init_step ? r_fill : r_wr[PAGE_W-1:BIT_AW];
    assign mem_wdata = i_cmd.init_step ? '1 : wr_word;
    assign mem_raddr = i_cmd.fetch_scan ? r_pos[PAGE_W-1:BIT_AW] : r_wr[PAGE_W-1:BIT_AW];

    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_waddr] <= mem_wdata;
        if (i_cmd.fetch_scan || i_cmd.fetch_wr) r_word <= r_map[mem_raddr];
        else if (wr_act) r_word <= wr_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RST;
            r_cursor <= '0;
            r_fcnt   <= '0;
            r_fill   <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_cursor <= n_cursor;
            if (i_cmd.init_step) r_fill <= r_fill + 1'b1;
            if (i_cmd.load) begin
                r_op   <= i_op;
                r_n    <= i_count;
                r_left <= i_count;
                r_wr   <= {1'b0, i_first};
                r_old  <= r_cursor;
            end
            if (i_cmd.scan_start) begin
                r_pos <= r_cursor; r_to <= lim; r_run <= '0; r_found <= 1'b0;
            end
            if (i_cmd.scan_retry) begin
                r_pos <= '0; r_to <= bound; r_run <= '0;
            end
            if (i_cmd.scan_step) begin
                r_pos <= r_pos + 1'b1;
                if (bit_u) r_run <= '0;
                else begin
                    r_run <= r_run + 1'b1;
                    if (run_hit) begin
                        r_found <= 1'b1;
                        r_start <= r_pos + 1'b1 - r_n;
                        r_wr    <= r_pos + 1'b1 - r_n;
                        r_left  <= r_n;
                    end
                end
            end
            if (i_cmd.mark_step || i_cmd.clear_step) begin
                r_wr   <= r_wr + 1'b1;
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.commit_alloc) begin
                r_fcnt <= (r_fcnt > r_n) ? r_fcnt - r_n : '0;
                r_page <= r_start[PAGE_W-1:0]; r_ok <= 1'b1;
            end
            // free request keeps its full 13-bit count for the tally
            if (i_cmd.commit_free) begin
                r_fcnt <= (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];
                r_page <= '0; r_ok <= 1'b1;
            end
            if (i_cmd.commit_fail) begin r_page <= '0; r_ok <= 1'b0; end
        end
    end

    always_comb begin
        n_cursor = r_cursor;
        if (i_cmd.scan_step) n_cursor = r_pos + 1'b1;
        else if (i_cmd.scan_retry) n_cursor = bound;
    end

    assign o_stat.is_free   = r_op;
    assign o_stat.zero_req  = (r_n == '0);
    assign o_stat.scan_end  = (r_pos >= r_to);
    assign o_stat.found     = r_found;
    assign o_stat.scan_wrap = (r_pos[BIT_AW-1:0] == '1);
    assign o_stat.wr_wrap   = (r_wr[BIT_AW-1:0] == '1);
    // stop once the walk reaches the limit: nothing beyond it changes
    assign o_stat.wr_done   = (r_left == '0) || (r_wr >= lim);
    assign o_stat.init_done = (r_fill == '1);
    assign o_page = r_page;
    assign o_ok   = r_ok;
    assign o_free = r_fcnt;
endmodule

// File: hw/rtl/bpa_ctrl.sv
// Controller of the bitmap page allocator: sequences the fill pass, scan,
// retry, word fetches, mark and clear passes and the output handshake. Uses bpa_pkg.
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  bpa_pkg::t_stat i_stat,
    output bpa_pkg::t_cmd  o_cmd
);
    import bpa_pkg::*;
    localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_LOAD = 3'd2,
                           S_SFETCH = 3'd3, S_SCAN = 3'd4, S_WFETCH = 3'd5,
                           S_WRITE = 3'd6, S_OUT = 3'd7;
    logic [2:0] r_state, n_state;
    logic       r_pass2, n_pass2;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin r_state <= S_INIT; r_pass2 <= 1'b0; end
        else begin r_state <= n_state; r_pass2 <= n_pass2; end
    end

    always_comb begin
        n_state = r_state;
        n_pass2 = r_pass2;
        o_cmd = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_done) n_state = S_IDLE;
            end
            S_IDLE: if (i_req_valid) begin o_cmd.load = 1'b1; n_state = S_LOAD; end
            S_LOAD: begin
                if (i_stat.is_free) begin
                    if (i_stat.wr_done) begin o_cmd.commit_free = 1'b1; n_state = S_OUT; end
                    else n_state = S_WFETCH;
                end
                else if (i_stat.zero_req) begin o_cmd.commit_fail = 1'b1; n_state = S_OUT; end
                else begin o_cmd.scan_start = 1'b1; n_pass2 = 1'b0; n_state = S_SFETCH; end
            end
            S_SFETCH: begin o_cmd.fetch_scan = 1'b1; n_state = S_SCAN; end
            S_SCAN: begin
                if (i_stat.found) n_state = S_WFETCH;
                else if (i_stat.scan_end) begin
                    if (r_pass2) begin o_cmd.commit_fail = 1'b1; n_state = S_OUT; end
                    else begin
                        o_cmd.scan_retry = 1'b1; n_pass2 = 1'b1; n_state = S_SFETCH;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                    // refetch once the scan leaves the buffered word
                    if (i_stat.scan_wrap) n_state = S_SFETCH;
                end
            end
            S_WFETCH: begin o_cmd.fetch_wr = 1'b1; n_state = S_WRITE; end
            S_WRITE: begin
                if (i_stat.wr_done) begin
                    if (i_stat.is_free) o_cmd.commit_free = 1'b1;
                    else o_cmd.commit_alloc = 1'b1;
                    n_state = S_OUT;
                end else begin
                    if (i_stat.is_free) o_cmd.clear_step = 1'b1;
                    else o_cmd.mark_step = 1'b1;
                    if (i_stat.wr_wrap) n_state = S_WFETCH;
                end
            end
            S_OUT: if (i_rsp_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/bpa_checker.sv
// Port-level checker for the bitmap page allocator, bound to the top.
// Depends on bitmap_page_allocator ports only.
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("request taken during response");
    a_fail_page0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[11:0] == 12'd0))
        else $error("failed grant with nonzero page");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("response dropped");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:25] == 7'd0)) else $error("pad bits set");
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

// File: test/bitmap_page_allocator_tb.sv
// Testbench for bitmap_page_allocator: drives allocate and free requests on the
// input stream and checks every grant against a page-map predictor.
// Depends on bpa_pkg and the bitmap_page_allocator RTL.
`timescale 1ns / 100ps

typedef struct {
    logic [11:0] page;
    logic        ok;
    logic [12:0] total;
} t_grant;

class page_map_scoreboard;
    bit          used_map[4096];
    int unsigned cursor;
    int unsigned free_cnt;
    int unsigned limit;
    t_grant      pending[$];
    int unsigned errors;
    int unsigned grants_seen;
    int unsigned alloc_ok;
    int unsigned alloc_fail;
    int unsigned frees;

    function new();
        foreach (used_map[i]) used_map[i] = 1'b1;
        cursor   = 0;
        free_cnt = 0;
        limit    = 4096;
    endfunction

    // Look for n clear pages in a row inside [from, to); pos ends where the scan stopped.
    function bit find_run(int unsigned from, int unsigned to, int unsigned n,
                          output int unsigned start, output int unsigned pos);
        int unsigned p;
        int unsigned run;
        p   = from;
        run = 0;
        start = 0;
        while (p < to) begin
            if (!used_map[p]) begin
                run++;
                if (run == n) begin
                    start = p + 1 - n;
                    pos   = p + 1;
                    return 1'b1;
                end
            end else begin
                run = 0;
            end
            p++;
        end
        pos = p;
        return 1'b0;
    endfunction

    function void note_request(logic op, logic [11:0] first, logic [12:0] n);
        int unsigned lim;
        int unsigned start;
        int unsigned pos;
        int unsigned old;
        bit          found;
        t_grant      g;
        lim = (limit > 4096) ? 4096 : limit;
        g.page  = '0;
        g.ok    = 1'b0;
        if (op == bpa_pkg::OP_ALLOC) begin
            if (n != 0) begin
                old   = cursor;
                found = find_run(old, lim, n, start, pos);
                if (!found)
                    found = find_run(0, (old < lim) ? old : lim, n, start, pos);
                cursor = pos;
                if (found) begin
                    for (int unsigned i = start; i < start + n; i++) used_map[i] = 1'b1;
                    free_cnt = (free_cnt > n) ? free_cnt - n : 0;
                    g.page = start[11:0];
                    g.ok   = 1'b1;
                end
            end
            if (g.ok) alloc_ok++; else alloc_fail++;
        end else begin
            for (int unsigned i = 0; i < n; i++)
                if (first + i < lim) used_map[first + i] = 1'b0;
            free_cnt = free_cnt + n;
            if (free_cnt > 8191) free_cnt = 8191;
            g.ok = 1'b1;
            frees++;
        end
        g.total = free_cnt[12:0];
        pending.push_back(g);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] grant error: %s", $time, msg);
        errors++;
    endtask

    task check_grant(logic [11:0] page, logic ok, logic [12:0] total);
        t_grant g;
        grants_seen++;
        if (pending.size() == 0) begin
            report_mismatch("grant with no request outstanding");
        end else begin
            g = pending.pop_front();
            if (page !== g.page)
                report_mismatch($sformatf("page %0d, want %0d", page, g.page));
            if (ok !== g.ok)
                report_mismatch($sformatf("granted %b, want %b", ok, g.ok));
            if (total !== g.total)
                report_mismatch($sformatf("free total %0d, want %0d", total, g.total));
        end
    endtask
endclass

module bitmap_page_allocator_tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // first_page[11:0], page_count[24:12], zero
    logic        s_axis_tuser;  // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // granted_page[11:0], free_total[24:12], zero
    logic        m_axis_tuser;  // granted

    page_map_scoreboard sb;
    int unsigned burst_left;
    int unsigned hold_request;
    int unsigned requests_sent;

    bitmap_page_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Grant side: stall on a changing pattern, plus one long hold-off on request.
    initial begin
        int unsigned mode;
        int unsigned stretch;
        int unsigned hold;
        mode = 0;
        stretch = 0;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_grant(m_axis_tdata[11:0], m_axis_tuser, m_axis_tdata[24:12]);
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (stretch == 0) begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(8, 60);
            end
            stretch--;
            if (hold != 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else begin
                case (mode)
                    0, 1: m_axis_tready = 1'b1;
                    2:    m_axis_tready = ($urandom_range(0, 1) == 1);
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one request; returns at a falling edge once it has been taken.
    task send_request(logic op, logic [11:0] first, logic [12:0] n);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'b0, n, first};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, first, n);
        requests_sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task drain_grants();
        // drop valid so the last request is not taken twice
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task write_limit(logic [12:0] value);
        drain_grants();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.limit   = value;
    endtask

    task random_request(int unsigned lim);
        int unsigned r;
        int unsigned first;
        int unsigned span;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            span = (lim < 24) ? ((lim == 0) ? 1 : lim) : 24;
            send_request(bpa_pkg::OP_ALLOC, 12'($urandom_range(0, 4095)),
                         13'((r < 4 && lim != 0) ? $urandom_range(1, lim)
                                                 : $urandom_range(1, span)));
        end else if (r < 80 && lim != 0) begin
            first = $urandom_range(0, lim - 1);
            span  = (lim - first < 16) ? lim - first : 16;
            send_request(bpa_pkg::OP_FREE, 12'(first), 13'($urandom_range(1, span)));
        end else if (r < 86) begin
            send_request(bpa_pkg::OP_ALLOC, 12'($urandom_range(0, 4095)),
                         (r < 83) ? 13'd0 : 13'($urandom_range(0, 4096)));
        end else if (r < 94) begin
            send_request(bpa_pkg::OP_FREE, 12'($urandom_range(0, 4095)),
                         13'($urandom_range(0, 64)));
        end else begin
            send_request(bpa_pkg::OP_FREE, 12'($urandom_range(0, 4095)),
                         13'($urandom_range(0, 4096)));
        end
    endtask

    initial begin
        int unsigned limits[9];
        int unsigned lim;
        sb = new();
        limits = '{64, 16, 200, 512, 8191, 3, 1000, 64, 300};
        burst_left = 0;
        hold_request = 0;
        requests_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty map, zero-page request, saturation, whole-map run, wrap retry
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd0);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        send_request(bpa_pkg::OP_FREE, 12'd0, 13'd4096);
        send_request(bpa_pkg::OP_FREE, 12'd0, 13'd4096);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd4096);
        send_request(bpa_pkg::OP_FREE, 12'd4095, 13'd1);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        send_request(bpa_pkg::OP_FREE, 12'd100, 13'd50);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd8);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd43);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd8191);
        // No pages managed: frees land beyond the limit but still count
        write_limit(13'd0);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        send_request(bpa_pkg::OP_FREE, 12'd5, 13'd3);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        write_limit(13'd1);
        send_request(bpa_pkg::OP_FREE, 12'd0, 13'd2);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
        write_limit(13'd8191);
        send_request(bpa_pkg::OP_FREE, 12'd4000, 13'd200);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd96);
        send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);

        // Random phases; mostly small limits keep each scan short
        foreach (limits[ph]) begin
            write_limit(13'(limits[ph]));
            lim = (limits[ph] > 4096) ? 4096 : limits[ph];
            // Hold off the grant side so the request side backs up
            if (ph == 2) hold_request = 400;
            repeat ((lim >= 4096) ? 15 : 48) random_request(lim);
        end
        write_limit(13'd4096);
        repeat (5) random_request(4096);

        s_axis_tvalid = 1'b0;
        drain_grants();
        repeat (64) @(negedge i_clk);
        $display("Run covered %0d requests: %0d allocations granted, %0d refused, %0d frees.",
                 requests_sent, sb.alloc_ok, sb.alloc_fail, sb.frees);
        $display("Page limits swept from 0 through 8191; %0d grants checked, %0d errors.",
                 sb.grants_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
